// ===== rtl/spt_pkg.sv =====
// spt_pkg: shared types and constants of the sweep-and-prune pair tracker
// used by spt_ctrl, spt_dp and sweep_prune_pair_tracker; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package spt_pkg;

  localparam int NODES   = 64;
  localparam int NODE_W  = 6;
  localparam int COORD_W = 24;
  localparam int POS_W   = 7;
  localparam int CNT_W   = 8;

  localparam logic signed [COORD_W-1:0] SENT_V = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] CMAX_V = {1'b0, {(COORD_W-2){1'b1}}, 1'b0};
  localparam logic signed [COORD_W-1:0] CMIN_V = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [2:0] OPC_ADD    = 3'd0;
  localparam logic [2:0] OPC_REMOVE = 3'd1;
  localparam logic [2:0] OPC_DIRTY  = 3'd2;
  localparam logic [2:0] OPC_COMMIT = 3'd3;
  localparam logic [2:0] OPC_FETCH  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_DEGEN   = 2'd2;
  localparam logic [1:0] ST_BAD_HDL = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] val;
    logic                      is_min;
    logic [NODE_W-1:0]         node;
  } ep_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_LATCH, OP_DECODE, OP_INIT_ROW,
    OP_ADD0, OP_ADD1, OP_ADD2, OP_ADD3,
    OP_RMRD, OP_RMWR, OP_RMMRD, OP_RMMWR, OP_RMFIN,
    OP_DT0, OP_DT1,
    OP_CMCLR, OP_CMSCAN, OP_CMP0, OP_CMP1, OP_CMP2,
    OP_CMAX, OP_CMA1, OP_CMA2, OP_CMA3,
    OP_CMMV, OP_CMM1, OP_CMM2, OP_CMSL, OP_CMS1,
    OP_CMT0, OP_CMT1, OP_CMT2, OP_CMR0, OP_CMR1,
    OP_CMW0, OP_CMW1, OP_CMNX, OP_CMNN, OP_CMEND,
    OP_FTRD, OP_FTCK
  } dp_op_t;

  typedef struct packed {
    logic [2:0] opc;
    logic       ok;
    logic       r_lt_cnt;
    logic       ax;
    logic       row_last;
    logic       n_last;
    logic       node_sel;
    logic       mv_cond;
    logic       s_last;
    logic       sl_end;
    logic       swap;
    logic       ev_on;
    logic       ev_off;
    logic       fetch_hit;
    logic       fetch_end;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/spt_dp.sv =====
// spt_dp: endpoint lists, box stores, pair matrices and work registers
// executes one micro-operation per cycle from spt_ctrl; depends on spt_pkg
`timescale 1ns / 1ps
`default_nettype none
module spt_dp (
  input  wire                           clk,
  input  wire                           rst,
  input  spt_pkg::dp_op_t               cmd,
  output spt_pkg::dp_stat_t             stat,
  input  wire [2:0]                     opcode,
  input  wire [spt_pkg::NODE_W-1:0]     node_handle,
  input  wire signed [spt_pkg::COORD_W-1:0] min_x,
  input  wire signed [spt_pkg::COORD_W-1:0] min_y,
  input  wire signed [spt_pkg::COORD_W-1:0] max_x,
  input  wire signed [spt_pkg::COORD_W-1:0] max_y,
  input  wire [15:0]                    expn,
  output logic [spt_pkg::NODE_W-1:0]    new_handle,
  output logic [1:0]                    status,
  output logic                          change_valid,
  output logic                          change_kind,
  output logic [spt_pkg::NODE_W-1:0]    pair_low,
  output logic [spt_pkg::NODE_W-1:0]    pair_high
);
  import spt_pkg::*;

  localparam int BW = 2 * COORD_W;

  // latched request
  logic [2:0]                op_r;
  logic [NODE_W-1:0]         h_r;
  logic signed [COORD_W-1:0] cx0, cy0, cx1, cy1;

  // control state
  logic [NODES-1:0]  live, dirty;
  logic [CNT_W-1:0]  cnt;
  logic [NODE_W-1:0] row;
  logic              fk;
  logic [NODE_W-1:0] frow;

  // work registers
  logic [NODE_W-1:0]         n;
  logic                      ax;
  logic [1:0]                s;
  logic [POS_W-1:0]          pos;
  logic                      dir_up;
  ep_t                       cur, nbr;
  logic [CNT_W-1:0]          rix, wix;
  logic signed [COORD_W-1:0] bx_lo [2];
  logic signed [COORD_W-1:0] bx_hi [2];
  logic signed [COORD_W-1:0] olo, ohi;
  logic                      tx, touch, is_on;

  // memories
  ep_t              lmem [256];
  ep_t              lrd;
  logic             l_we;
  logic [7:0]       l_wa, l_ra;
  ep_t              l_wd;
  logic [POS_W-1:0] pmem [256];
  logic [POS_W-1:0] prd, p_wd;
  logic             p_we;
  logic [7:0]       p_wa, p_ra;
  logic [BW-1:0]    bmem [128];
  logic [BW-1:0]    brd, b_wd;
  logic             b_we;
  logic [6:0]       b_wa, b_ra;
  logic [BW-1:0]    qmem [128];
  logic [BW-1:0]    qrd, q_wd;
  logic             q_we;
  logic [6:0]       q_wa, q_ra;
  logic [NODES-1:0] omem [NODES];
  logic [NODES-1:0] amem [NODES];
  logic [NODES-1:0] dmem [NODES];
  logic [NODES-1:0] ord, ard, drd, o_wd, a_wd, d_wd;
  logic             o_we, a_we, d_we;
  logic [NODE_W-1:0] m_ra, m_wa;

  function automatic logic signed [COORD_W-1:0] rd_coord(input logic signed [COORD_W-1:0] v);
    rd_coord = (v == SENT_V) ? CMAX_V : v;
  endfunction

  function automatic logic signed [COORD_W-1:0] grow(input logic signed [COORD_W-1:0] v,
                                                     input logic [15:0] e,
                                                     input logic up);
    logic signed [COORD_W+1:0] t;
    logic signed [COORD_W+1:0] ee;
    ee = $signed({{(COORD_W+2-16){1'b0}}, e});
    t  = up ? ($signed({{2{v[COORD_W-1]}}, v}) + ee) : ($signed({{2{v[COORD_W-1]}}, v}) - ee);
    if (t < CMIN_V) grow = CMIN_V;
    else if (t > CMAX_V) grow = CMAX_V;
    else grow = t[COORD_W-1:0];
  endfunction

  function automatic logic [NODE_W-1:0] low_bit(input logic [NODES-1:0] v);
    low_bit = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (v[i]) low_bit = NODE_W'(i);
    end
  endfunction

  function automatic logic ax_touch(input logic [BW-1:0] b,
                                    input logic signed [COORD_W-1:0] lo,
                                    input logic signed [COORD_W-1:0] hi);
    logic signed [COORD_W-1:0] blo, bhi;
    blo = b[BW-1:COORD_W];
    bhi = b[COORD_W-1:0];
    ax_touch = !(blo > hi || lo > bhi);
  endfunction

  // derived values
  logic                      degen, full;
  logic [NODE_W-1:0]         free_idx;
  logic [POS_W-1:0]          nx, cnt_lo, cnt_hi;
  logic signed [COORD_W-1:0] mv_v;
  logic                      ep_ev, g_on, g_off;
  logic [NODE_W-1:0]         p_lo, p_hi;
  logic [NODES-1:0]          hbit, fbits, fsel;
  logic [NODE_W-1:0]         fj;

  assign degen    = !(cx1 > cx0 && cy1 > cy0);
  assign full     = &live;
  assign free_idx = low_bit(~live);
  assign nx       = dir_up ? pos + 1'b1 : pos - 1'b1;
  assign cnt_lo   = cnt[POS_W-1:0];
  assign cnt_hi   = cnt[POS_W-1:0] + 1'b1;
  assign mv_v     = s[0] ? bx_hi[ax] : bx_lo[ax];
  assign ep_ev    = (lrd.val != SENT_V) && (lrd.node != cur.node);
  assign g_on     = dir_up ? (!cur.is_min && lrd.is_min) : (cur.is_min && !lrd.is_min);
  assign g_off    = dir_up ? (cur.is_min && !lrd.is_min) : (!cur.is_min && lrd.is_min);
  assign p_lo     = (cur.node < nbr.node) ? cur.node : nbr.node;
  assign p_hi     = (cur.node < nbr.node) ? nbr.node : cur.node;
  assign hbit     = NODES'(1) << p_hi;
  assign fbits    = fk ? drd : ard;
  assign fj       = low_bit(fbits);
  assign fsel     = fbits & ~(NODES'(1) << fj);

  always_comb begin
    stat.opc       = op_r;
    stat.ok        = (status == ST_OK);
    stat.r_lt_cnt  = (rix < cnt);
    stat.ax        = ax;
    stat.row_last  = (row == NODE_W'(NODES - 1));
    stat.n_last    = (n == NODE_W'(NODES - 1));
    stat.node_sel  = live[n] && dirty[n];
    unique case (s)
      2'd0: stat.mv_cond = bx_lo[ax] < olo;
      2'd1: stat.mv_cond = bx_hi[ax] > ohi;
      2'd2: stat.mv_cond = bx_lo[ax] >= olo;
      default: stat.mv_cond = bx_hi[ax] <= ohi;
    endcase
    stat.s_last    = (s == 2'd3);
    stat.sl_end    = dir_up ? ({1'b0, pos} + 1'b1 >= cnt) : (pos == '0);
    stat.swap      = dir_up ? (lrd.val < cur.val) : (lrd.val > cur.val);
    stat.ev_on     = ep_ev && g_on;
    stat.ev_off    = ep_ev && g_off;
    stat.fetch_hit = |fbits;
    stat.fetch_end = fk && (frow == NODE_W'(NODES - 1));
  end

  // memory ports
  always_comb begin
    l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
    p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
    b_we = 1'b0; b_wa = '0; b_wd = '0; b_ra = '0;
    q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
    o_we = 1'b0; a_we = 1'b0; d_we = 1'b0;
    o_wd = '0; a_wd = '0; d_wd = '0;
    m_ra = '0; m_wa = '0;
    unique case (cmd)
      OP_INIT_ROW: begin
        m_wa = row; o_we = 1'b1; a_we = 1'b1; d_we = 1'b1;
      end
      OP_ADD0: begin
        l_we = 1'b1; l_wa = {1'b0, cnt_lo}; l_wd = '{SENT_V, 1'b1, n};
        p_we = 1'b1; p_wa = {n, 2'b00}; p_wd = cnt_lo;
        b_we = 1'b1; b_wa = {n, 1'b0}; b_wd = {cx0, cx1};
        q_we = 1'b1; q_wa = {n, 1'b0}; q_wd = {cx0, cx1};
      end
      OP_ADD1: begin
        l_we = 1'b1; l_wa = {1'b0, cnt_hi}; l_wd = '{SENT_V, 1'b0, n};
        p_we = 1'b1; p_wa = {n, 2'b01}; p_wd = cnt_hi;
        b_we = 1'b1; b_wa = {n, 1'b1}; b_wd = {cy0, cy1};
        q_we = 1'b1; q_wa = {n, 1'b1}; q_wd = {cy0, cy1};
      end
      OP_ADD2: begin
        l_we = 1'b1; l_wa = {1'b1, cnt_lo}; l_wd = '{SENT_V, 1'b1, n};
        p_we = 1'b1; p_wa = {n, 2'b10}; p_wd = cnt_lo;
      end
      OP_ADD3: begin
        l_we = 1'b1; l_wa = {1'b1, cnt_hi}; l_wd = '{SENT_V, 1'b0, n};
        p_we = 1'b1; p_wa = {n, 2'b11}; p_wd = cnt_hi;
      end
      OP_RMRD: l_ra = {ax, rix[POS_W-1:0]};
      OP_RMWR: begin
        if (lrd.node != h_r) begin
          l_we = 1'b1; l_wa = {ax, wix[POS_W-1:0]}; l_wd = lrd;
          p_we = 1'b1; p_wa = {lrd.node, ax, ~lrd.is_min}; p_wd = wix[POS_W-1:0];
        end
      end
      OP_RMMRD: m_ra = row;
      OP_RMMWR: begin
        m_wa = row; o_we = 1'b1; a_we = 1'b1; d_we = 1'b1;
        if (row != h_r) begin
          o_wd = ord & ~(NODES'(1) << h_r);
          a_wd = ard & ~(NODES'(1) << h_r);
          d_wd = drd & ~(NODES'(1) << h_r);
        end
      end
      OP_DT0: begin
        q_we = 1'b1; q_wa = {h_r, 1'b0};
        q_wd = {grow(cx0, expn, 1'b0), grow(cx1, expn, 1'b1)};
      end
      OP_DT1: begin
        q_we = 1'b1; q_wa = {h_r, 1'b1};
        q_wd = {grow(cy0, expn, 1'b0), grow(cy1, expn, 1'b1)};
      end
      OP_CMCLR: begin
        m_wa = row; a_we = 1'b1; d_we = 1'b1;
      end
      OP_CMP0: q_ra = {n, 1'b0};
      OP_CMP1: begin
        q_ra = {n, 1'b1};
        b_we = 1'b1; b_wa = {n, 1'b0}; b_wd = qrd;
      end
      OP_CMP2: begin
        b_we = 1'b1; b_wa = {n, 1'b1}; b_wd = qrd;
      end
      OP_CMAX: p_ra = {n, ax, 1'b0};
      OP_CMA1: begin
        p_ra = {n, ax, 1'b1}; l_ra = {ax, prd};
      end
      OP_CMA2: l_ra = {ax, prd};
      OP_CMMV: p_ra = {n, ax, s[0]};
      OP_CMM1: l_ra = {ax, prd};
      OP_CMM2: begin
        l_we = 1'b1; l_wa = {ax, pos}; l_wd = '{mv_v, lrd.is_min, lrd.node};
      end
      OP_CMSL: l_ra = {ax, nx};
      OP_CMT0: b_ra = {nbr.node, 1'b0};
      OP_CMT1: b_ra = {nbr.node, 1'b1};
      OP_CMR0: m_ra = p_lo;
      OP_CMR1: begin
        m_wa = p_lo;
        if (is_on) begin
          if (!(|(ord & hbit)) && touch) begin
            o_we = 1'b1; o_wd = ord | hbit;
            if (|(drd & hbit)) begin
              d_we = 1'b1; d_wd = drd & ~hbit;
            end else begin
              a_we = 1'b1; a_wd = ard | hbit;
            end
          end
        end else if (|(ord & hbit)) begin
          o_we = 1'b1; o_wd = ord & ~hbit;
          if (|(ard & hbit)) begin
            a_we = 1'b1; a_wd = ard & ~hbit;
          end else begin
            d_we = 1'b1; d_wd = drd | hbit;
          end
        end
      end
      OP_CMW0: begin
        l_we = 1'b1; l_wa = {ax, pos}; l_wd = nbr;
        p_we = 1'b1; p_wa = {nbr.node, ax, ~nbr.is_min}; p_wd = pos;
      end
      OP_CMW1: begin
        l_we = 1'b1; l_wa = {ax, nx}; l_wd = cur;
        p_we = 1'b1; p_wa = {cur.node, ax, ~cur.is_min}; p_wd = nx;
      end
      OP_FTRD: m_ra = frow;
      OP_FTCK: begin
        m_wa = frow;
        if (|fbits) begin
          a_we = !fk; d_we = fk;
          a_wd = fsel; d_wd = fsel;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (l_we) lmem[l_wa] <= l_wd;
    lrd <= lmem[l_ra];
    if (p_we) pmem[p_wa] <= p_wd;
    prd <= pmem[p_ra];
    if (b_we) bmem[b_wa] <= b_wd;
    brd <= bmem[b_ra];
    if (q_we) qmem[q_wa] <= q_wd;
    qrd <= qmem[q_ra];
    if (o_we) omem[m_wa] <= o_wd;
    if (a_we) amem[m_wa] <= a_wd;
    if (d_we) dmem[m_wa] <= d_wd;
    ord <= omem[m_ra];
    ard <= amem[m_ra];
    drd <= dmem[m_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
      dirty <= '0;
      cnt <= '0;
      row <= '0;
      fk <= 1'b0;
      frow <= '0;
    end else begin
      unique case (cmd)
        OP_DECODE: begin
          row <= '0;
          if (op_r == OPC_COMMIT) begin
            fk <= 1'b0;
            frow <= '0;
          end
        end
        OP_INIT_ROW, OP_RMMWR, OP_CMCLR: row <= row + 1'b1;
        OP_ADD3: begin
          cnt <= cnt + CNT_W'(2);
          live[n] <= 1'b1;
          dirty[n] <= 1'b1;
        end
        OP_RMFIN: begin
          cnt <= cnt - CNT_W'(2);
          live[h_r] <= 1'b0;
          dirty[h_r] <= 1'b0;
        end
        OP_DT1: dirty[h_r] <= 1'b1;
        OP_CMEND: dirty <= '0;
        OP_FTCK: begin
          if (!(|fbits) && !(fk && frow == NODE_W'(NODES - 1))) begin
            {fk, frow} <= {fk, frow} + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // work and result registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      OP_LATCH: begin
        op_r <= opcode;
        h_r  <= node_handle;
        cx0  <= rd_coord(min_x);
        cy0  <= rd_coord(min_y);
        cx1  <= rd_coord(max_x);
        cy1  <= rd_coord(max_y);
      end
      OP_DECODE: begin
        new_handle   <= '0;
        status       <= ST_OK;
        change_valid <= 1'b0;
        change_kind  <= 1'b0;
        pair_low     <= '0;
        pair_high    <= '0;
        ax  <= 1'b0;
        rix <= '0;
        wix <= '0;
        n   <= (op_r == OPC_COMMIT) ? '0 : h_r;
        unique case (op_r)
          OPC_ADD: begin
            if (degen) status <= ST_DEGEN;
            else if (full) status <= ST_FULL;
            else begin
              new_handle <= free_idx;
              n <= free_idx;
            end
          end
          OPC_REMOVE: if (!live[h_r]) status <= ST_BAD_HDL;
          OPC_DIRTY: begin
            if (!live[h_r]) status <= ST_BAD_HDL;
            else if (degen) status <= ST_DEGEN;
          end
          default: begin
          end
        endcase
      end
      OP_RMRD: begin
        if (rix < cnt) rix <= rix + 1'b1;
        else begin
          ax <= 1'b1;
          rix <= '0;
          wix <= '0;
        end
      end
      OP_RMWR: if (lrd.node != h_r) wix <= wix + 1'b1;
      OP_CMSCAN: if (!(live[n] && dirty[n])) n <= n + 1'b1;
      OP_CMP1: begin
        bx_lo[0] <= qrd[BW-1:COORD_W];
        bx_hi[0] <= qrd[COORD_W-1:0];
      end
      OP_CMP2: begin
        bx_lo[1] <= qrd[BW-1:COORD_W];
        bx_hi[1] <= qrd[COORD_W-1:0];
        ax <= 1'b0;
      end
      OP_CMA2: olo <= lrd.val;
      OP_CMA3: begin
        ohi <= lrd.val;
        s <= 2'd0;
      end
      OP_CMM1: pos <= prd;
      OP_CMM2: begin
        cur    <= '{mv_v, lrd.is_min, lrd.node};
        dir_up <= !(mv_v < lrd.val);
      end
      OP_CMS1: begin
        nbr   <= lrd;
        is_on <= g_on;
      end
      OP_CMT1: tx <= ax_touch(brd, bx_lo[0], bx_hi[0]);
      OP_CMT2: touch <= tx && ax_touch(brd, bx_lo[1], bx_hi[1]);
      OP_CMW1: pos <= nx;
      OP_CMNX: begin
        s <= s + 1'b1;
        if (s == 2'd3) ax <= ~ax;
      end
      OP_CMNN: n <= n + 1'b1;
      OP_FTCK: begin
        if (|fbits) begin
          change_valid <= 1'b1;
          change_kind  <= fk;
          pair_low     <= frow;
          pair_high    <= fj;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/spt_ctrl.sv =====
// spt_ctrl: command sequencer of the sweep-and-prune pair tracker
// drives one datapath micro-operation per cycle; depends on spt_pkg
`timescale 1ns / 1ps
`default_nettype none
module spt_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  output logic               done,
  output spt_pkg::dp_op_t    cmd,
  input  spt_pkg::dp_stat_t  stat
);
  import spt_pkg::*;

  typedef enum logic [5:0] {
    S_INIT, S_IDLE, S_DECODE, S_ROUTE,
    S_ADD0, S_ADD1, S_ADD2, S_ADD3,
    S_RMRD, S_RMWR, S_RMMRD, S_RMMWR, S_RMFIN,
    S_DT0, S_DT1,
    S_CMCLR, S_CMSCAN, S_CMP0, S_CMP1, S_CMP2,
    S_CMAX, S_CMA1, S_CMA2, S_CMA3,
    S_CMMV, S_CMM1, S_CMM2, S_CMSL, S_CMS1,
    S_CMT0, S_CMT1, S_CMT2, S_CMR0, S_CMR1,
    S_CMW0, S_CMW1, S_CMNX, S_CMNN, S_CMEND,
    S_FTRD, S_FTCK, S_EMIT
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);
  assign done = (state == S_EMIT);

  always_comb begin
    unique case (state)
      S_INIT:   cmd = OP_INIT_ROW;
      S_IDLE:   cmd = start ? OP_LATCH : OP_NOP;
      S_DECODE: cmd = OP_DECODE;
      S_ADD0:   cmd = OP_ADD0;
      S_ADD1:   cmd = OP_ADD1;
      S_ADD2:   cmd = OP_ADD2;
      S_ADD3:   cmd = OP_ADD3;
      S_RMRD:   cmd = OP_RMRD;
      S_RMWR:   cmd = OP_RMWR;
      S_RMMRD:  cmd = OP_RMMRD;
      S_RMMWR:  cmd = OP_RMMWR;
      S_RMFIN:  cmd = OP_RMFIN;
      S_DT0:    cmd = OP_DT0;
      S_DT1:    cmd = OP_DT1;
      S_CMCLR:  cmd = OP_CMCLR;
      S_CMSCAN: cmd = OP_CMSCAN;
      S_CMP0:   cmd = OP_CMP0;
      S_CMP1:   cmd = OP_CMP1;
      S_CMP2:   cmd = OP_CMP2;
      S_CMAX:   cmd = OP_CMAX;
      S_CMA1:   cmd = OP_CMA1;
      S_CMA2:   cmd = OP_CMA2;
      S_CMA3:   cmd = OP_CMA3;
      S_CMMV:   cmd = OP_CMMV;
      S_CMM1:   cmd = OP_CMM1;
      S_CMM2:   cmd = OP_CMM2;
      S_CMSL:   cmd = OP_CMSL;
      S_CMS1:   cmd = OP_CMS1;
      S_CMT0:   cmd = OP_CMT0;
      S_CMT1:   cmd = OP_CMT1;
      S_CMT2:   cmd = OP_CMT2;
      S_CMR0:   cmd = OP_CMR0;
      S_CMR1:   cmd = OP_CMR1;
      S_CMW0:   cmd = OP_CMW0;
      S_CMW1:   cmd = OP_CMW1;
      S_CMNX:   cmd = OP_CMNX;
      S_CMNN:   cmd = OP_CMNN;
      S_CMEND:  cmd = OP_CMEND;
      S_FTRD:   cmd = OP_FTRD;
      S_FTCK:   cmd = OP_FTCK;
      default:  cmd = OP_NOP;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:   if (stat.row_last) state_next = S_IDLE;
      S_IDLE:   if (start) state_next = S_DECODE;
      S_DECODE: state_next = S_ROUTE;
      S_ROUTE: begin
        unique case (stat.opc)
          OPC_ADD:    state_next = stat.ok ? S_ADD0 : S_EMIT;
          OPC_REMOVE: state_next = stat.ok ? S_RMRD : S_EMIT;
          OPC_DIRTY:  state_next = stat.ok ? S_DT0 : S_EMIT;
          OPC_COMMIT: state_next = S_CMCLR;
          OPC_FETCH:  state_next = S_FTRD;
          default:    state_next = S_EMIT;
        endcase
      end
      S_ADD0: state_next = S_ADD1;
      S_ADD1: state_next = S_ADD2;
      S_ADD2: state_next = S_ADD3;
      S_ADD3: state_next = S_EMIT;
      S_RMRD: begin
        priority if (stat.r_lt_cnt) state_next = S_RMWR;
        else if (stat.ax) state_next = S_RMMRD;
        else state_next = S_RMRD;
      end
      S_RMWR:  state_next = S_RMRD;
      S_RMMRD: state_next = S_RMMWR;
      S_RMMWR: state_next = stat.row_last ? S_RMFIN : S_RMMRD;
      S_RMFIN: state_next = S_EMIT;
      S_DT0:   state_next = S_DT1;
      S_DT1:   state_next = S_EMIT;
      S_CMCLR: if (stat.row_last) state_next = S_CMSCAN;
      S_CMSCAN: begin
        priority if (stat.node_sel) state_next = S_CMP0;
        else if (stat.n_last) state_next = S_CMEND;
        else state_next = S_CMSCAN;
      end
      S_CMP0: state_next = S_CMP1;
      S_CMP1: state_next = S_CMP2;
      S_CMP2: state_next = S_CMAX;
      S_CMAX: state_next = S_CMA1;
      S_CMA1: state_next = S_CMA2;
      S_CMA2: state_next = S_CMA3;
      S_CMA3: state_next = S_CMMV;
      S_CMMV: state_next = stat.mv_cond ? S_CMM1 : S_CMNX;
      S_CMM1: state_next = S_CMM2;
      S_CMM2: state_next = S_CMSL;
      S_CMSL: state_next = stat.sl_end ? S_CMNX : S_CMS1;
      S_CMS1: begin
        priority if (!stat.swap) state_next = S_CMNX;
        else if (stat.ev_on) state_next = S_CMT0;
        else if (stat.ev_off) state_next = S_CMR0;
        else state_next = S_CMW0;
      end
      S_CMT0: state_next = S_CMT1;
      S_CMT1: state_next = S_CMT2;
      S_CMT2: state_next = S_CMR0;
      S_CMR0: state_next = S_CMR1;
      S_CMR1: state_next = S_CMW0;
      S_CMW0: state_next = S_CMW1;
      S_CMW1: state_next = S_CMSL;
      S_CMNX: begin
        priority if (!stat.s_last) state_next = S_CMMV;
        else if (stat.ax) state_next = S_CMNN;
        else state_next = S_CMAX;
      end
      S_CMNN:  state_next = stat.n_last ? S_CMEND : S_CMSCAN;
      S_CMEND: state_next = S_EMIT;
      S_FTRD:  state_next = S_FTCK;
      S_FTCK:  state_next = (stat.fetch_hit || stat.fetch_end) ? S_EMIT : S_FTRD;
      S_EMIT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sweep_prune_pair_tracker.sv =====
// sweep_prune_pair_tracker: top level of the two-axis sweep-and-prune tracker
// holds the register port and joins spt_ctrl and spt_dp; depends on spt_pkg
//
// usage
//   requests: drive opcode, node_handle and the box corners with start high;
//   a request is taken at a clock edge where start is high and busy is low.
//   one result per request: done is high for one cycle with new_handle,
//   status, change_valid, change_kind, pair_low and pair_high; it must be
//   taken in that cycle, there is no back-pressure.
//   work per request: remove makes one pass over each of the two endpoint
//   lists, then one pass over the 64 matrix rows; fetch scans the pair
//   matrix rows until it finds a pair; commit clears the added and dropped
//   matrices, then moves the endpoints of each dirty node and handles each
//   endpoint swap; one request at a time
//   reset: the pair matrices are cleared one row per cycle and busy stays
//   high until all rows are clear; the register port works meanwhile
//   the expansion register sits at byte address 0 of the register port
`timescale 1ns / 1ps
`default_nettype none
module sweep_prune_pair_tracker (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               start,
  output logic                              busy,
  input  wire [2:0]                         opcode,
  input  wire [spt_pkg::NODE_W-1:0]         node_handle,
  input  wire signed [spt_pkg::COORD_W-1:0] min_x,
  input  wire signed [spt_pkg::COORD_W-1:0] min_y,
  input  wire signed [spt_pkg::COORD_W-1:0] max_x,
  input  wire signed [spt_pkg::COORD_W-1:0] max_y,
  output logic                              done,
  output logic [spt_pkg::NODE_W-1:0]        new_handle,
  output logic [1:0]                        status,
  output logic                              change_valid,
  output logic                              change_kind,
  output logic [spt_pkg::NODE_W-1:0]        pair_low,
  output logic [spt_pkg::NODE_W-1:0]        pair_high,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [2:0]                         paddr,
  input  wire [31:0]                        pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import spt_pkg::*;

  logic [15:0] expn;
  dp_op_t      cmd;
  dp_stat_t    stat;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, expn};

  always_ff @(posedge clk) begin
    if (rst) begin
      expn <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      expn <= pwdata[15:0];
    end
  end

  spt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  spt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (opcode),
    .node_handle  (node_handle),
    .min_x        (min_x),
    .min_y        (min_y),
    .max_x        (max_x),
    .max_y        (max_y),
    .expn         (expn),
    .new_handle   (new_handle),
    .status       (status),
    .change_valid (change_valid),
    .change_kind  (change_kind),
    .pair_low     (pair_low),
    .pair_high    (pair_high)
  );

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a request");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("no return to idle after result");
  a_take: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("request taken without going busy");
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
      (done && change_valid) |-> (pair_low < pair_high))
    else $error("pair handles out of order");
`endif

endmodule
`default_nettype wire
